// ===== design/cbw_pkg.sv =====
// Package: types, codes and defaults for the CBOR item walker.
package cbw_pkg;

    localparam int MAX_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EARLY    = 3'd1,
        ERR_ADDL     = 3'd2,
        ERR_INDEF    = 3'd3,
        ERR_OVERRUN  = 3'd4,
        ERR_SIMPLE   = 3'd5,
        ERR_DEEP     = 3'd6
    } err_t;

    localparam logic [2:0] MAJ_UINT  = 3'd0;
    localparam logic [2:0] MAJ_NEG   = 3'd1;
    localparam logic [2:0] MAJ_BYTES = 3'd2;
    localparam logic [2:0] MAJ_TEXT  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    localparam logic [4:0] AI_ONE_BYTE = 5'd24;
    localparam logic [4:0] AI_INDEF    = 5'd31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        token_valid;
        logic [3:0]  value_type;
        logic [63:0] argument;
        logic [4:0]  nesting_depth;
        logic        item_done;
        logic [31:0] item_length;
        logic [2:0]  error_code;
    } out_beat_t;

endpackage

// ===== design/cbw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module cbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== design/cbor_item_walker.sv =====
// Top level: streaming CBOR header walker with a RAM-held container stack.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_beat_t   | in_valid / in_stall
//   out     | output    | out_beat_t  | out_valid / out_stall
//
// Each input beat passes through an accept cycle, which reads the top stack entry from RAM,
// and a step cycle, which decodes and updates. Each container that closes adds a read of the
// next level (S_POP_RD), then a decision (S_POP); a cascade of pops repeats these two states.
// The stack entries are written before being read, guarded by level_reg,
// so no clearing pass follows reset. A beat held at the output keeps the walker in its
// step or pop state; in_stall is high whenever the walker is not idle.
module cbor_item_walker
    import cbw_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);
    localparam int AW = $clog2(MAX_DEPTH);
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int EW = 65;

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_POP_RD, S_POP} state_t;

    state_t      state_reg;
    in_beat_t    beat_reg;
    logic [LW-1:0] level_reg;
    logic [63:0] accum_reg;
    logic [3:0]  argleft_reg;
    logic [2:0]  major_reg;
    logic [63:0] payload_reg;
    logic [31:0] count_reg;
    logic        discard_reg;
    logic        pend_last_reg;
    out_beat_t   pend_reg;
    logic        out_valid_reg;
    out_beat_t   out_reg;

    state_t      state_next;
    in_beat_t    beat_next;
    logic [LW-1:0] level_next;
    logic [63:0] accum_next;
    logic [3:0]  argleft_next;
    logic [2:0]  major_next;
    logic [63:0] payload_next;
    logic [31:0] count_next;
    logic        discard_next;
    logic        pend_last_next;
    out_beat_t   pend_next;
    logic        out_valid_next;
    out_beat_t   out_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    cbw_ram #(.WIDTH(EW), .DEPTH(MAX_DEPTH)) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [LW-1:0] level_m1;
    assign level_m1 = level_reg - LW'(1);

    always_comb
    begin
        rd_addr = (level_reg == '0) ? '0 : level_m1[AW-1:0];
    end

    logic hold;
    assign hold      = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // step decode
    logic        s_err_any, s_finish, s_hdr, s_push, s_clear, s_noop;
    logic [2:0]  s_err;
    logic [2:0]  s_major;
    logic [63:0] s_arg;
    logic [3:0]  s_type;
    logic [63:0] s_accum_n, s_payload_n;
    logic [3:0]  s_argleft_n;
    logic [2:0]  s_major_n;
    logic [31:0] s_count_n;
    logic [EW-1:0] s_push_val;
    logic [4:0]  ai;
    logic [2:0]  bmaj;

    always_comb
    begin
        ai = beat_reg.data_byte[4:0];
        bmaj = beat_reg.data_byte[7:5];
        s_err = ERR_NONE;
        s_finish = 1'b0;
        s_hdr = 1'b0;
        s_push = 1'b0;
        s_clear = 1'b0;
        s_noop = 1'b0;
        s_major = major_reg;
        s_arg = '0;
        s_type = '0;
        s_accum_n = accum_reg;
        s_payload_n = payload_reg;
        s_argleft_n = argleft_reg;
        s_major_n = major_reg;
        s_count_n = count_reg;
        s_push_val = '0;
        if (!beat_reg.byte_valid)
        begin
            if (!beat_reg.last_byte)
            begin
                s_noop = 1'b1;
            end
            else if (discard_reg || count_reg == '0)
            begin
                s_clear = 1'b1;
            end
            else
            begin
                s_err = (payload_reg != '0) ? ERR_OVERRUN : ERR_EARLY;
            end
        end
        else if (discard_reg)
        begin
            s_noop = !beat_reg.last_byte;
            s_clear = beat_reg.last_byte;
        end
        else
        begin
            if (count_reg != '1)
            begin
                s_count_n = count_reg + 32'd1;
            end
            if (payload_reg != '0)
            begin
                s_payload_n = payload_reg - 64'd1;
                if (s_payload_n == '0)
                begin
                    s_finish = 1'b1;
                end
                else if (beat_reg.last_byte)
                begin
                    s_err = ERR_OVERRUN;
                end
            end
            else if (argleft_reg != '0)
            begin
                s_accum_n = {accum_reg[55:0], beat_reg.data_byte};
                s_argleft_n = argleft_reg - 4'd1;
                if (s_argleft_n == '0)
                begin
                    s_hdr = 1'b1;
                    s_arg = s_accum_n;
                end
                else if (beat_reg.last_byte)
                begin
                    s_err = ERR_EARLY;
                end
            end
            else
            begin
                s_major = bmaj;
                s_major_n = bmaj;
                if (ai >= 5'd28 && ai <= 5'd30)
                begin
                    s_err = ERR_ADDL;
                end
                else if (bmaj == MAJ_SIMPLE)
                begin
                    if (ai >= 5'd20 && ai <= 5'd23)
                    begin
                        s_hdr = 1'b1;
                        s_arg = 64'(ai);
                    end
                    else
                    begin
                        s_err = ERR_SIMPLE;
                    end
                end
                else if (ai == AI_INDEF)
                begin
                    s_err = (bmaj >= MAJ_BYTES && bmaj <= MAJ_MAP) ? ERR_INDEF : ERR_ADDL;
                end
                else if (ai < AI_ONE_BYTE)
                begin
                    s_hdr = 1'b1;
                    s_arg = 64'(ai);
                end
                else
                begin
                    s_argleft_n = 4'd1 << (ai[1:0]);
                    s_accum_n = '0;
                    if (beat_reg.last_byte)
                    begin
                        s_err = ERR_EARLY;
                    end
                end
            end
            if (s_hdr)
            begin
                s_type = {1'b0, s_major};
                unique case (s_major)
                    MAJ_UINT, MAJ_NEG:
                    begin
                        s_finish = 1'b1;
                    end
                    MAJ_BYTES, MAJ_TEXT:
                    begin
                        if (s_arg == '0)
                        begin
                            s_finish = 1'b1;
                        end
                        else if (beat_reg.last_byte)
                        begin
                            s_err = ERR_OVERRUN;
                        end
                        else
                        begin
                            s_payload_n = s_arg;
                        end
                    end
                    MAJ_ARRAY, MAJ_MAP, MAJ_TAG:
                    begin
                        if (s_major != MAJ_TAG && s_arg == '0)
                        begin
                            s_finish = 1'b1;
                        end
                        else if (level_reg >= LW'(MAX_DEPTH))
                        begin
                            s_err = ERR_DEEP;
                        end
                        else
                        begin
                            s_push = 1'b1;
                            if (s_major == MAJ_ARRAY)
                            begin
                                s_push_val = {1'b0, s_arg};
                            end
                            else if (s_major == MAJ_MAP)
                            begin
                                s_push_val = {s_arg, 1'b0};
                            end
                            else
                            begin
                                s_push_val = 65'd1;
                            end
                        end
                    end
                    default:
                    begin
                        s_type = 4'd7 + {2'b00, s_arg[1:0] - 2'd0};
                        s_finish = 1'b1;
                    end
                endcase
            end
        end
        s_err_any = (s_err != ERR_NONE);
    end

    // pop decision against the top entry
    logic [EW-1:0] top_dec;
    assign top_dec = rd_data - EW'(1);

    out_beat_t tok_beat;
    always_comb
    begin
        tok_beat = '0;
        tok_beat.token_valid = 1'b1;
        tok_beat.value_type = s_type;
        tok_beat.argument = s_arg;
        tok_beat.nesting_depth = 5'(level_reg);
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = level_reg[AW-1:0];
        wr_data = s_push_val;
        if (state_reg == S_STEP && !hold && !s_err_any && s_push)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == S_STEP && !hold && !s_err_any && s_finish &&
                  level_reg != '0) ||
                 (state_reg == S_POP && !hold && level_reg != '0))
        begin
            wr_en = (top_dec != '0);
            wr_addr = level_m1[AW-1:0];
            wr_data = top_dec;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        beat_next = beat_reg;
        level_next = level_reg;
        accum_next = accum_reg;
        argleft_next = argleft_reg;
        major_next = major_reg;
        payload_next = payload_reg;
        count_next = count_reg;
        discard_next = discard_reg;
        pend_last_next = pend_last_reg;
        pend_next = pend_reg;
        out_valid_next = hold;
        out_next = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    beat_next = in_data;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!hold)
                begin
                    state_next = S_IDLE;
                    if (s_clear)
                    begin
                        level_next = '0;
                        accum_next = '0;
                        argleft_next = '0;
                        major_next = '0;
                        payload_next = '0;
                        count_next = '0;
                        discard_next = 1'b0;
                    end
                    else if (s_noop)
                    begin
                    end
                    else if (s_err_any)
                    begin
                        level_next = '0;
                        accum_next = '0;
                        argleft_next = '0;
                        major_next = '0;
                        payload_next = '0;
                        count_next = '0;
                        discard_next = !beat_reg.last_byte;
                        out_next = '0;
                        out_next.error_code = s_err;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        accum_next = s_accum_n;
                        argleft_next = s_argleft_n;
                        major_next = s_major_n;
                        payload_next = s_payload_n;
                        count_next = s_count_n;
                        pend_next = s_hdr ? tok_beat : '0;
                        if (s_push)
                        begin
                            level_next = level_reg + LW'(1);
                        end
                        if (s_finish && level_reg == '0)
                        begin
                            out_next = s_hdr ? tok_beat : '0;
                            out_next.item_done = 1'b1;
                            out_next.item_length = s_count_n;
                            count_next = '0;
                            out_valid_next = 1'b1;
                        end
                        else if (s_finish)
                        begin
                            if (top_dec != '0)
                            begin
                                if (beat_reg.last_byte)
                                begin
                                    level_next = '0;
                                    accum_next = '0;
                                    argleft_next = '0;
                                    major_next = '0;
                                    payload_next = '0;
                                    count_next = '0;
                                    out_next = '0;
                                    out_next.error_code = ERR_EARLY;
                                    out_valid_next = 1'b1;
                                end
                                else if (s_hdr)
                                begin
                                    out_next = tok_beat;
                                    out_valid_next = 1'b1;
                                end
                            end
                            else
                            begin
                                level_next = level_m1;
                                pend_last_next = beat_reg.last_byte;
                                state_next = S_POP_RD;
                            end
                        end
                        else if (beat_reg.last_byte)
                        begin
                            level_next = '0;
                            accum_next = '0;
                            argleft_next = '0;
                            major_next = '0;
                            payload_next = '0;
                            count_next = '0;
                            out_next = '0;
                            out_next.error_code = ERR_EARLY;
                            out_valid_next = 1'b1;
                        end
                        else if (s_hdr)
                        begin
                            out_next = tok_beat;
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_POP_RD:
            begin
                // read of the new top is in flight
                state_next = S_POP;
            end
            S_POP:
            begin
                if (!hold)
                begin
                    state_next = S_IDLE;
                    if (level_reg == '0)
                    begin
                        out_next = pend_reg;
                        out_next.item_done = 1'b1;
                        out_next.item_length = count_reg;
                        count_next = '0;
                        out_valid_next = 1'b1;
                    end
                    else if (top_dec == '0)
                    begin
                        level_next = level_m1;
                        state_next = S_POP_RD;
                    end
                    else if (pend_last_reg)
                    begin
                        level_next = '0;
                        accum_next = '0;
                        argleft_next = '0;
                        major_next = '0;
                        payload_next = '0;
                        count_next = '0;
                        out_next = '0;
                        out_next.error_code = ERR_EARLY;
                        out_valid_next = 1'b1;
                    end
                    else if (pend_reg.token_valid)
                    begin
                        out_next = pend_reg;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            beat_reg <= '0;
            level_reg <= '0;
            accum_reg <= '0;
            argleft_reg <= '0;
            major_reg <= '0;
            payload_reg <= '0;
            count_reg <= '0;
            discard_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            pend_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg <= beat_next;
            level_reg <= level_next;
            accum_reg <= accum_next;
            argleft_reg <= argleft_next;
            major_reg <= major_next;
            payload_reg <= payload_next;
            count_reg <= count_next;
            discard_reg <= discard_next;
            pend_last_reg <= pend_last_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
            out_reg <= out_next;
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(MAX_DEPTH))
        else $error("stack level beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("accept while busy");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code != ERR_NONE) |->
        (!out_data.token_valid && !out_data.item_done))
        else $error("error beat carries data");
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.item_done) |-> (out_data.item_length != '0))
        else $error("zero item length");
endmodule
